FILE: hdl/ise_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interpolation search engine package
// Shared widths, action codes and the controller state type.
// ----------------------------------------------------------------------------
package ise_pkg;

  localparam int unsigned ValW   = 32;
  localparam int unsigned IndexW = 10;
  localparam int unsigned CountW = 11;

  localparam logic ActionWrite  = 1'b0;
  localparam logic ActionSearch = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_RD_LOW,
    S_RD_HIGH,
    S_MUL,
    S_DIV,
    S_PROBE,
    S_CMP,
    S_OUT
  } state_e;

endpackage

FILE: hdl/ise_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interpolation search engine channels
// Request, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface ise_req_if;
  logic                                valid;
  logic                                ready;
  logic                                action;
  logic [ise_pkg::IndexW-1:0]          entry_index;
  logic signed [ise_pkg::ValW-1:0]     entry_value;
  logic signed [ise_pkg::ValW-1:0]     search_key;
  modport source (output valid, action, entry_index, entry_value, search_key, input ready);
  modport sink   (input valid, action, entry_index, entry_value, search_key, output ready);
endinterface

interface ise_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       found;
  logic [ise_pkg::IndexW-1:0] position;
  modport source (output valid, found, position, input ready);
  modport sink   (input valid, found, position, output ready);
endinterface

interface ise_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [ise_pkg::CountW-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

FILE: hdl/interpolation_search_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interpolation search engine
// Sorted table with an interpolation search over a shift-add multiplier and a
// restoring divider.
// ----------------------------------------------------------------------------
// A write item stores one entry. A search item runs, per probe, table reads and
// compares, a bit-serial multiply (one bit of the window width per cycle) and
// a restoring division over 32 + log2(TABLE_DEPTH) quotient bits (one quotient
// bit per cycle); a flat window skips both. Uniform data needs only a few
// probes. One item is worked on at a time; a finished result waits in the
// output register while the next item is taken.
module interpolation_search_engine #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ise_req_if.sink   req_i,
  ise_rsp_if.source rsp_o,
  ise_cfg_if.sink   cfg_i
);

  localparam int unsigned IW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned SW  = IW + 2;          // signed window bounds
  localparam int unsigned PW  = ise_pkg::ValW + IW;
  localparam int unsigned DCW = $clog2(PW + 1);
  localparam int unsigned EW  = (IW + 1 > ise_pkg::CountW) ? IW + 1 : ise_pkg::CountW;

  ise_pkg::state_e state_q, state_d;

  logic [ise_pkg::CountW-1:0]      count_q;
  logic signed [SW-1:0]            low_q, high_q;
  logic signed [ise_pkg::ValW-1:0] key_q, tl_q, rdata_q;
  logic [PW-1:0]                   mcand_q, prod_q, num_q;
  logic [IW-1:0]                   mplier_q, quot_q, probe_q;
  logic [ise_pkg::ValW-1:0]        den_q, rem_q;
  logic [DCW-1:0]                  dcnt_q;
  logic                            res_found_q;
  logic                            out_valid_q, out_found_q;
  logic [ise_pkg::IndexW-1:0]      out_pos_q;

  logic signed [ise_pkg::ValW-1:0] mem [TABLE_DEPTH];
  logic [IW-1:0]                   raddr, waddr;
  logic                            we, req_xfer, search_xfer;
  logic [EW-1:0]                   n_ext;
  logic                            n_zero, out_range, flat, hit, tp_gt;
  logic [ise_pkg::ValW-1:0]        key_diff;
  logic [PW-1:0]                   prod_next;
  logic [IW-1:0]                   mplier_next;
  logic [ise_pkg::ValW:0]          trial;
  logic                            qbit;
  logic [IW-1:0]                   quot_next;
  logic                            out_free;

  assign cfg_i.ready = 1'b1;
  assign req_i.ready = (state_q == ise_pkg::S_IDLE);
  assign req_xfer    = req_i.valid && req_i.ready;
  assign search_xfer = req_xfer && (req_i.action == ise_pkg::ActionSearch);

  assign n_ext  = (EW'(count_q) > EW'(TABLE_DEPTH)) ? EW'(TABLE_DEPTH) : EW'(count_q);
  assign n_zero = (n_ext == '0);

  // In S_RD_HIGH the read register holds t[high].
  assign out_range = (key_q < tl_q) || (key_q > rdata_q);
  assign flat      = (rdata_q == tl_q);
  assign hit       = (rdata_q == key_q);
  assign tp_gt     = (rdata_q > key_q);

  // The key lies at or above t[low] here, so the unsigned difference is exact.
  assign key_diff    = key_q - tl_q;
  assign prod_next   = mplier_q[0] ? prod_q + mcand_q : prod_q;
  assign mplier_next = mplier_q >> 1;
  assign trial       = {rem_q, num_q[PW-1]};
  assign qbit        = (trial >= {1'b0, den_q});
  assign quot_next   = IW'({quot_q, qbit});
  assign out_free    = !out_valid_q || rsp_o.ready;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ise_pkg::S_IDLE: begin
        if (search_xfer) state_d = n_zero ? ise_pkg::S_OUT : ise_pkg::S_CHECK;
      end
      ise_pkg::S_CHECK:   state_d = (low_q > high_q) ? ise_pkg::S_OUT : ise_pkg::S_RD_LOW;
      ise_pkg::S_RD_LOW:  state_d = ise_pkg::S_RD_HIGH;
      ise_pkg::S_RD_HIGH: begin
        if (out_range)  state_d = ise_pkg::S_OUT;
        else if (flat)  state_d = ise_pkg::S_PROBE;
        else            state_d = ise_pkg::S_MUL;
      end
      ise_pkg::S_MUL:   if (mplier_next == '0) state_d = ise_pkg::S_DIV;
      ise_pkg::S_DIV:   if (dcnt_q == DCW'(1)) state_d = ise_pkg::S_PROBE;
      ise_pkg::S_PROBE: state_d = ise_pkg::S_CMP;
      ise_pkg::S_CMP:   state_d = hit ? ise_pkg::S_OUT : ise_pkg::S_CHECK;
      ise_pkg::S_OUT:   if (out_free) state_d = ise_pkg::S_IDLE;
      default:          state_d = ise_pkg::S_IDLE;
    endcase
  end

  // Table port control.
  always_comb begin
    raddr = low_q[IW-1:0];
    we    = 1'b0;
    waddr = IW'(req_i.entry_index);
    unique case (state_q)
      ise_pkg::S_IDLE: begin
        we = req_xfer && (req_i.action == ise_pkg::ActionWrite)
             && (32'(req_i.entry_index) < 32'(TABLE_DEPTH));
      end
      ise_pkg::S_RD_LOW: raddr = high_q[IW-1:0];
      ise_pkg::S_PROBE:  raddr = probe_q;
      default:           raddr = low_q[IW-1:0];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= req_i.entry_value;
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ise_pkg::S_IDLE;
      count_q     <= ise_pkg::CountW'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid && cfg_i.ready) count_q <= cfg_i.data;
      if (state_q == ise_pkg::S_OUT && out_free) out_valid_q <= 1'b1;
      else if (rsp_o.ready) out_valid_q <= 1'b0;
    end
  end

  // Search datapath.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ise_pkg::S_IDLE: begin
        key_q       <= req_i.search_key;
        low_q       <= '0;
        high_q      <= SW'(n_ext) - SW'(1);
        res_found_q <= 1'b0;
      end
      ise_pkg::S_RD_LOW: tl_q <= rdata_q;
      ise_pkg::S_RD_HIGH: begin
        probe_q  <= low_q[IW-1:0];
        mcand_q  <= PW'(key_diff);
        mplier_q <= IW'(high_q - low_q);
        prod_q   <= '0;
        den_q    <= rdata_q - tl_q;
      end
      ise_pkg::S_MUL: begin
        prod_q   <= prod_next;
        mcand_q  <= mcand_q << 1;
        mplier_q <= mplier_next;
        num_q    <= prod_next;
        rem_q    <= '0;
        quot_q   <= '0;
        dcnt_q   <= DCW'(PW);
      end
      ise_pkg::S_DIV: begin
        rem_q   <= qbit ? ise_pkg::ValW'(trial - {1'b0, den_q}) : trial[ise_pkg::ValW-1:0];
        num_q   <= num_q << 1;
        quot_q  <= quot_next;
        dcnt_q  <= dcnt_q - DCW'(1);
        probe_q <= low_q[IW-1:0] + quot_next;
      end
      ise_pkg::S_CMP: begin
        if (hit) res_found_q <= 1'b1;
        else if (tp_gt) high_q <= SW'(probe_q) - SW'(1);
        else low_q <= SW'(probe_q) + SW'(1);
      end
      ise_pkg::S_OUT: begin
        if (out_free) begin
          out_found_q <= res_found_q;
          out_pos_q   <= res_found_q ? ise_pkg::IndexW'(probe_q) : '0;
        end
      end
      default: ;
    endcase
  end

  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.found    = out_found_q;
  assign rsp_o.position = out_pos_q;

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interpolation search engine testbench
// Fills the table with sorted data under several entry counts, then runs
// directed and random searches and table rewrites. Each search answer is
// checked against an in-bench search over a shadow copy of the table.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned Depth    = 1024;
  localparam int unsigned MaxCycle = 40000000;

  typedef struct packed {
    logic                           found;
    logic [ise_pkg::IndexW-1:0]     position;
  } answer_t;

  logic clk_i;
  logic rst_ni;

  ise_req_if req_if ();
  ise_rsp_if rsp_if ();
  ise_cfg_if cfg_if ();

  interpolation_search_engine #(.TABLE_DEPTH(Depth)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source),
    .cfg_i  (cfg_if.sink)
  );

  logic signed [ise_pkg::ValW-1:0] shadow_table [Depth];
  int unsigned            active_count;
  answer_t                pending_answers [$];
  int unsigned            errors;
  int unsigned            searches_checked;
  int unsigned            writes_sent;
  longint unsigned        cycle_count;
  bit                     long_hold;
  int unsigned            burst_left;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > MaxCycle) begin
        $display("Timeout after %0d cycles", cycle_count);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Interpolation search over the shadow table; exact in 64 bits.
  function automatic answer_t search_table(logic signed [ise_pkg::ValW-1:0] key);
    answer_t     res;
    longint      n, lo, hi, tl, th, tp, probe, k;
    longint unsigned num, den;
    res = '0;
    n = (active_count > Depth) ? Depth : active_count;
    k = key;
    if (n == 0) return res;
    lo = 0;
    hi = n - 1;
    while (lo <= hi) begin
      tl = shadow_table[lo];
      th = shadow_table[hi];
      if (k < tl || k > th) return res;
      if (th == tl) probe = lo;
      else begin
        num = longint'(k - tl) * longint'(hi - lo);
        den = th - tl;
        probe = lo + longint'(num / den);
      end
      tp = shadow_table[probe];
      if (tp == k) begin
        res.found = 1'b1;
        res.position = probe[ise_pkg::IndexW-1:0];
        return res;
      end
      if (tp > k) hi = probe - 1;
      else lo = probe + 1;
    end
    return res;
  endfunction

  // Sender gaps: bursts of random length separated by random idle stretches.
  task automatic sender_gap();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 20)) @(negedge clk_i);
    end
    burst_left--;
  endtask

  task automatic send_item(logic act, logic [ise_pkg::IndexW-1:0] idx,
                           logic signed [ise_pkg::ValW-1:0] val,
                           logic signed [ise_pkg::ValW-1:0] key);
    sender_gap();
    req_if.valid       = 1'b1;
    req_if.action      = act;
    req_if.entry_index = idx;
    req_if.entry_value = val;
    req_if.search_key  = key;
    do @(posedge clk_i); while (!req_if.ready);
    // Predict at the accepting edge so order matches the block.
    if (act == ise_pkg::ActionWrite) begin
      shadow_table[idx] = val;
      writes_sent++;
    end else begin
      pending_answers.push_back(search_table(key));
    end
    @(negedge clk_i);
    req_if.valid = 1'b0;
  endtask

  task automatic write_entry(int unsigned idx, logic signed [ise_pkg::ValW-1:0] val);
    send_item(ise_pkg::ActionWrite, idx[ise_pkg::IndexW-1:0], val, $urandom());
  endtask

  task automatic search_key(logic signed [ise_pkg::ValW-1:0] key);
    send_item(ise_pkg::ActionSearch, ise_pkg::IndexW'($urandom()), $urandom(), key);
  endtask

  task automatic wait_idle();
    while (pending_answers.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
  endtask

  task automatic set_count(logic [ise_pkg::CountW-1:0] value);
    wait_idle();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    active_count = value;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Sorted fill of entries [0, n) with a chosen spread; steps may repeat values.
  task automatic fill_sorted(int unsigned n, int unsigned max_step, longint start);
    longint v;
    v = start;
    for (int unsigned i = 0; i < n; i++) begin
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      write_entry(i, v[ise_pkg::ValW-1:0]);
      v += $urandom_range(0, max_step);
    end
  endtask

  // A key that is either a table hit, a near miss or anything at all.
  function automatic logic signed [ise_pkg::ValW-1:0] pick_key();
    int unsigned n, i;
    n = (active_count > Depth) ? Depth : active_count;
    i = $urandom_range(0, n - 1);
    case ($urandom_range(0, 3))
      0, 1: return shadow_table[i];
      2:    return shadow_table[i] + $signed($urandom_range(0, 2)) - 1;
      default: return $urandom();
    endcase
  endfunction

  task automatic test_directed();
    set_count(11'd1);
    write_entry(0, 32'sh8000_0000);
    search_key(32'sh8000_0000);
    search_key(32'sh7fff_ffff);
    write_entry(0, 32'sh7fff_ffff);
    search_key(32'sh7fff_ffff);
    write_entry(1, 32'sh8000_0000);
    write_entry(2, 32'sh0000_0000);
    write_entry(3, 32'sh7fff_ffff);
    set_count(11'd4);
    write_entry(0, 32'sh8000_0000);
    write_entry(1, 32'sh8000_0000);
    search_key(32'sh8000_0000);
    search_key(32'sh0000_0000);
    search_key(32'sh7fff_ffff);
    search_key(32'sh0000_0001);
    // Flat window: every entry equal.
    for (int unsigned i = 0; i < 4; i++) write_entry(i, 32'sd5);
    search_key(32'sd5);
    search_key(32'sd4);
    set_count(11'd0);
    search_key(32'sd5);
  endtask

  task automatic test_full_table();
    fill_sorted(Depth, 1 << 20, -64'sd2147483648);
    set_count(11'd2047);
    for (int unsigned i = 0; i < 30; i++) search_key(pick_key());
    write_entry(Depth - 1, 32'sh7fff_ffff);
    search_key(32'sh7fff_ffff);
    set_count(11'd1024);
    for (int unsigned i = 0; i < 30; i++) search_key(pick_key());
  endtask

  task automatic test_random_phases();
    int unsigned n;
    for (int unsigned phase = 0; phase < 4; phase++) begin
      n = (phase % 3 == 0) ? $urandom_range(1, 8) : $urandom_range(2, 64);
      set_count(n[ise_pkg::CountW-1:0]);
      fill_sorted(n, (phase[0]) ? 3 : $urandom_range(1, 1 << 24),
                  longint'($signed($urandom_range(0, 32'hffff))) - 64'sd40000);
      for (int unsigned i = 0; i < 20; i++) begin
        // Occasional noise: rewrites of entries beyond the searched range
        // or an unsorted rewrite inside it.
        if ($urandom_range(0, 9) == 0)
          write_entry($urandom_range(0, Depth - 1), $urandom());
        else
          search_key(pick_key());
      end
    end
  endtask

  task automatic test_backpressure();
    long_hold = 1'b1;
    for (int unsigned i = 0; i < 20; i++) search_key(pick_key());
    wait (long_hold == 1'b0);
  endtask

  // Receiver stalls on its own pattern, plus one long hold-off when asked.
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        rsp_if.ready <= 1'b0;
        repeat (3000) @(negedge clk_i);
        long_hold = 1'b0;
      end else if (cycle_count % 512 < 128) rsp_if.ready <= 1'b1;
      else rsp_if.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  initial begin
    answer_t exp_a;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp_if.valid && rsp_if.ready) begin
        if (pending_answers.size() == 0) begin
          $display("%0t: unexpected answer found=%0b position=%0d", $time,
                   rsp_if.found, rsp_if.position);
          errors++;
        end else begin
          exp_a = pending_answers.pop_front();
          if (rsp_if.found !== exp_a.found) begin
            $display("%0t: found expected %0b actual %0b", $time, exp_a.found,
                     rsp_if.found);
            errors++;
          end
          if (rsp_if.position !== exp_a.position) begin
            $display("%0t: position expected %0d actual %0d", $time,
                     exp_a.position, rsp_if.position);
            errors++;
          end
          searches_checked++;
        end
      end
    end
  end

  initial begin
    errors = 0;
    searches_checked = 0;
    writes_sent = 0;
    burst_left = 0;
    long_hold = 1'b0;
    active_count = 1;
    foreach (shadow_table[i]) shadow_table[i] = '0;
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.action = ise_pkg::ActionWrite;
    req_if.entry_index = '0;
    req_if.entry_value = '0;
    req_if.search_key = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);
    test_directed();
    test_full_table();
    test_random_phases();
    test_backpressure();
    wait_idle();
    $display("Covered %0d table writes and %0d checked searches over counts from", writes_sent,
             searches_checked);
    $display("zero to saturation, flat and unsorted windows, and a long output stall.");
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
